// File: src/capsule_sdf_line_pixel_blend_assert.svh
// Assertion macros for the capsule line shader.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef CAPSULE_SDF_LINE_PIXEL_BLEND_ASSERT_SVH
`define CAPSULE_SDF_LINE_PIXEL_BLEND_ASSERT_SVH

// cond must never hold outside reset
`define CSLPB_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// cond must hold in the cycle after reset is applied
`define CSLPB_AFTER_RESET(label, cond, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cond)) else $error(msg);

`endif

// File: src/cslpb_pkg.sv
// Shared widths, codes and transaction types for the capsule line shader.
// No dependencies.
package cslpb_pkg;

  localparam int COORD_BITS = 12;
  localparam int PIX_BITS   = COORD_BITS - 1;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int DOT_BITS   = 2 * COORD_BITS + 2;
  localparam int LEN2_BITS  = 2 * COORD_BITS + 1;
  localparam int H_FRAC     = 16;
  localparam int H_BITS     = H_FRAC + 1;
  localparam int NUM_BITS   = DIFF_BITS + H_FRAC + 2;
  localparam int DX_BITS    = COORD_BITS + 2;
  localparam int SQ_BITS    = 2 * COORD_BITS + 3;
  localparam int ROOT_BITS  = (SQ_BITS + H_FRAC + 1) / 2;
  localparam int RAD_BITS   = 2 * ROOT_BITS;
  localparam int REM_BITS   = ROOT_BITS + 2;

  localparam int COLOR_BITS    = 16;
  localparam int WIDTH_BITS    = 8;
  localparam int COV_BITS      = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int CNT_BITS      = 3;
  localparam int MIDQ_DEPTH    = 4;
  localparam int MIDQ_IDX      = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_COLOR = 2'd1;

  // how the projection fraction is formed
  typedef logic [1:0] hsel_t;
  localparam hsel_t HS_ZERO = 2'd0;
  localparam hsel_t HS_ONE  = 2'd1;
  localparam hsel_t HS_DIV  = 2'd2;

  typedef struct packed {
    logic signed [DIFF_BITS-1:0] pax;
    logic signed [DIFF_BITS-1:0] pay;
    logic signed [DIFF_BITS-1:0] bax;
    logic signed [DIFF_BITS-1:0] bay;
    hsel_t                       hsel;
    logic [COLOR_BITS-1:0]       bg;
  } side_t;

  typedef struct packed {
    side_t                side;
    logic [LEN2_BITS-1:0] dividend;
    logic [LEN2_BITS-1:0] divisor;
  } work_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] width;
    logic [COLOR_BITS-1:0] color;
  } cfg_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] count;
  } stat_t;

endpackage

// File: src/cslpb_front.sv
// Front end: endpoint offsets, dot products and projection classification.
// Uses cslpb_pkg.
module cslpb_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic [cslpb_pkg::PIX_BITS-1:0]       pixel_x,
  input  logic [cslpb_pkg::PIX_BITS-1:0]       pixel_y,
  input  logic signed [cslpb_pkg::COORD_BITS-1:0] start_x,
  input  logic signed [cslpb_pkg::COORD_BITS-1:0] start_y,
  input  logic signed [cslpb_pkg::COORD_BITS-1:0] end_x,
  input  logic signed [cslpb_pkg::COORD_BITS-1:0] end_y,
  input  logic [cslpb_pkg::COLOR_BITS-1:0]     background_color,
  output logic                                 q_push,
  output cslpb_pkg::work_t                     q_data,
  input  logic                                 q_full
);
  import cslpb_pkg::*;

  logic adv;

  logic                        v1_r, v2_r, v3_r;
  logic signed [DIFF_BITS-1:0] pax1_r, pay1_r, bax1_r, bay1_r;
  logic [COLOR_BITS-1:0]       bg1_r, bg2_r;
  logic signed [DIFF_BITS-1:0] pax2_r, pay2_r, bax2_r, bay2_r;
  logic signed [2*DIFF_BITS-1:0] ppx2_r, ppy2_r, bbx2_r, bby2_r;
  work_t                       w3_r;

  logic signed [DOT_BITS-1:0]  top;
  logic [LEN2_BITS-1:0]        len2;
  work_t                       w3_nxt;

  assign adv     = !q_full;
  assign in_full = q_full;
  assign q_push  = v3_r && adv;
  assign q_data  = w3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_push;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pax1_r <= $signed({2'b00, pixel_x}) - $signed({start_x[COORD_BITS-1], start_x});
      pay1_r <= $signed({2'b00, pixel_y}) - $signed({start_y[COORD_BITS-1], start_y});
      bax1_r <= $signed({end_x[COORD_BITS-1], end_x}) - $signed({start_x[COORD_BITS-1], start_x});
      bay1_r <= $signed({end_y[COORD_BITS-1], end_y}) - $signed({start_y[COORD_BITS-1], start_y});
      bg1_r  <= background_color;

      ppx2_r <= pax1_r * bax1_r;
      ppy2_r <= pay1_r * bay1_r;
      bbx2_r <= bax1_r * bax1_r;
      bby2_r <= bay1_r * bay1_r;
      pax2_r <= pax1_r;
      pay2_r <= pay1_r;
      bax2_r <= bax1_r;
      bay2_r <= bay1_r;
      bg2_r  <= bg1_r;

      w3_r <= w3_nxt;
    end
  end

  always_comb begin
    top  = DOT_BITS'(ppx2_r) + DOT_BITS'(ppy2_r);
    len2 = LEN2_BITS'(bbx2_r) + LEN2_BITS'(bby2_r);
    w3_nxt.side.pax = pax2_r;
    w3_nxt.side.pay = pay2_r;
    w3_nxt.side.bax = bax2_r;
    w3_nxt.side.bay = bay2_r;
    w3_nxt.side.bg  = bg2_r;
    w3_nxt.dividend = LEN2_BITS'(top);
    w3_nxt.divisor  = len2;
    // degenerate segment measures from the end point
    if (len2 == '0 || top >= $signed({1'b0, len2})) begin
      w3_nxt.side.hsel = HS_ONE;
    end else if (top[DOT_BITS-1] || top == '0) begin
      w3_nxt.side.hsel = HS_ZERO;
    end else begin
      w3_nxt.side.hsel = HS_DIV;
    end
  end

endmodule

// File: src/cslpb_queue.sv
// Short queue between the front end and the back end.
// Uses cslpb_pkg.
module cslpb_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cslpb_pkg::work_t push_data,
  input  logic             pop,
  output cslpb_pkg::work_t pop_data,
  output logic             empty,
  output logic             full,
  output cslpb_pkg::stat_t stat
);
  import cslpb_pkg::*;

  work_t               mem_r [MIDQ_DEPTH];
  logic [MIDQ_IDX-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0] count_r;

  assign empty      = (count_r == '0);
  assign full       = (count_r == CNT_BITS'(MIDQ_DEPTH));
  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/cslpb_div.sv
// Pipelined restoring divider for the projection fraction, one bit per stage.
// Uses cslpb_pkg.
module cslpb_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  cslpb_pkg::work_t             in_data,
  output logic                         out_valid,
  output logic [cslpb_pkg::H_FRAC-1:0] out_quo,
  output cslpb_pkg::side_t             out_side
);
  import cslpb_pkg::*;

  logic [H_FRAC-1:0]    v_r;
  logic [LEN2_BITS-1:0] rem_r [H_FRAC];
  logic [LEN2_BITS-1:0] dvs_r [H_FRAC];
  logic [H_FRAC-1:0]    quo_r [H_FRAC];
  side_t                side_r [H_FRAC];

  for (genvar k = 0; k < H_FRAC; k++) begin : g_stage
    logic                 v_i;
    logic [LEN2_BITS-1:0] rem_i, dvs_i;
    logic [H_FRAC-1:0]    quo_i;
    side_t                side_i;
    logic [LEN2_BITS:0]   sh;
    logic [LEN2_BITS+1:0] df;
    logic                 ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = in_data.dividend;
      assign dvs_i  = in_data.divisor;
      assign quo_i  = '0;
      assign side_i = in_data.side;
    end else begin : g_next
      assign v_i    = v_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign dvs_i  = dvs_r[k-1];
      assign quo_i  = quo_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign sh = {rem_i, 1'b0};
    assign df = {1'b0, sh} - {2'b00, dvs_i};
    assign ge = !df[LEN2_BITS+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? df[LEN2_BITS-1:0] : sh[LEN2_BITS-1:0];
        dvs_r[k]  <= dvs_i;
        quo_r[k]  <= {quo_i[H_FRAC-2:0], ge};
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = v_r[H_FRAC-1];
  assign out_quo   = quo_r[H_FRAC-1];
  assign out_side  = side_r[H_FRAC-1];

endmodule

// File: src/cslpb_sqrt.sv
// Pipelined digit-by-digit integer square root of (sq << 16), one root bit per stage.
// Uses cslpb_pkg.
module cslpb_sqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [cslpb_pkg::SQ_BITS-1:0]    in_sq,
  input  logic [cslpb_pkg::COLOR_BITS-1:0] in_bg,
  output logic                             out_valid,
  output logic [cslpb_pkg::ROOT_BITS-1:0]  out_root,
  output logic [cslpb_pkg::COLOR_BITS-1:0] out_bg
);
  import cslpb_pkg::*;

  logic [ROOT_BITS-1:0]  v_r;
  logic [RAD_BITS-1:0]   rad_r  [ROOT_BITS];
  logic [REM_BITS-1:0]   rem_r  [ROOT_BITS];
  logic [ROOT_BITS-1:0]  root_r [ROOT_BITS];
  logic [COLOR_BITS-1:0] bg_r   [ROOT_BITS];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    logic                  v_i;
    logic [RAD_BITS-1:0]   rad_i;
    logic [REM_BITS-1:0]   rem_i;
    logic [ROOT_BITS-1:0]  root_i;
    logic [COLOR_BITS-1:0] bg_i;
    logic [REM_BITS-1:0]   sh, test;
    logic [REM_BITS:0]     df;
    logic                  ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rad_i  = {{(RAD_BITS-SQ_BITS-H_FRAC){1'b0}}, in_sq, {H_FRAC{1'b0}}};
      assign rem_i  = '0;
      assign root_i = '0;
      assign bg_i   = in_bg;
    end else begin : g_next
      assign v_i    = v_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign bg_i   = bg_r[k-1];
    end

    // partial remainder never exceeds twice the partial root
    assign sh   = {rem_i[REM_BITS-3:0], rad_i[RAD_BITS-1 -: 2]};
    assign test = {root_i, 2'b01};
    assign df   = {1'b0, sh} - {1'b0, test};
    assign ge   = !df[REM_BITS];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= {rad_i[RAD_BITS-3:0], 2'b00};
        rem_r[k]  <= ge ? df[REM_BITS-1:0] : sh;
        root_r[k] <= {root_i[ROOT_BITS-2:0], ge};
        bg_r[k]   <= bg_i;
      end
    end
  end

  assign out_valid = v_r[ROOT_BITS-1];
  assign out_root  = root_r[ROOT_BITS-1];
  assign out_bg    = bg_r[ROOT_BITS-1];

endmodule

// File: src/cslpb_back.sv
// Back end: divide, offset, distance, coverage, RGB565 blend and result queue.
// Uses cslpb_pkg, cslpb_div and cslpb_sqrt.
module cslpb_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  output logic                             q_pop,
  input  cslpb_pkg::work_t                 q_data,
  input  cslpb_pkg::cfg_t                  cfg,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [cslpb_pkg::COLOR_BITS-1:0] out_blended_color,
  output logic [cslpb_pkg::COV_BITS-1:0]   out_coverage,
  output cslpb_pkg::stat_t                 stat
);
  import cslpb_pkg::*;

  function automatic logic [14:0] mix_pre(input logic [5:0] fg, input logic [5:0] bg,
                                          input logic [7:0] a);
    logic [14:0] fa;
    logic [14:0] ba;
    fa = {9'b0, fg} * {7'b0, a};
    ba = {9'b0, bg} * {7'b0, 8'd255 - a};
    return fa + ba + 15'd128;
  endfunction

  // divide by 255 through a reciprocal multiply
  function automatic logic [5:0] mix_post(input logic [14:0] x);
    logic [30:0] p;
    p = {16'b0, x} * 31'h8081;
    return p[23 +: 6];
  endfunction

  logic en;

  logic              div_v;
  logic [H_FRAC-1:0] div_q;
  side_t             div_side;

  logic                        v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic signed [DIFF_BITS-1:0] pax1_r, pay1_r;
  logic signed [NUM_BITS-1:0]  bxh1_r, byh1_r;
  logic [COLOR_BITS-1:0]       bg1_r, bg2_r, bg3_r, bg4_r, bg5_r;
  logic signed [DX_BITS-1:0]   dx2_r, dy2_r;
  logic [SQ_BITS-2:0]          sqx3_r, sqy3_r;
  logic [SQ_BITS-1:0]          sq4_r;
  logic [COV_BITS-1:0]         cov5_r, cov6_r, cov7_r;
  logic [14:0]                 xr6_r, xg6_r, xb6_r;
  logic [COLOR_BITS-1:0]       col7_r;

  logic [H_BITS-1:0]           h;
  logic signed [H_BITS:0]      h_s;
  logic signed [NUM_BITS-1:0]  numx, numy, tx, ty;
  logic signed [NUM_BITS-1:0]  round_adj;
  logic signed [2*DX_BITS-1:0] px, py;

  logic                        sq_v;
  logic [ROOT_BITS-1:0]        root_len;
  logic [COLOR_BITS-1:0]       sq_bg;
  logic [WIDTH_BITS+7:0]       rad128;
  logic [WIDTH_BITS+7:0]       diff;
  logic [8:0]                  t;
  logic [16:0]                 t255;

  // two-entry result queue
  logic [COLOR_BITS-1:0] oq_col_r [2];
  logic [COV_BITS-1:0]   oq_cov_r [2];
  logic                  oq_wr_r, oq_rd_r;
  logic [1:0]            oq_cnt_r;
  logic                  oq_push, oq_pop;

  assign en    = (oq_cnt_r != 2'd2);
  assign q_pop = en && !q_empty;

  cslpb_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (!q_empty),
    .in_data   (q_data),
    .out_valid (div_v),
    .out_quo   (div_q),
    .out_side  (div_side)
  );

  always_comb begin
    case (div_side.hsel)
      HS_ONE:  h = H_BITS'(1) << H_FRAC;
      HS_DIV:  h = {1'b0, div_q};
      default: h = '0;
    endcase
    h_s       = $signed({1'b0, h});
    round_adj = $signed({{(NUM_BITS-H_FRAC){1'b0}}, {H_FRAC{1'b1}}});
    numx = $signed({{(NUM_BITS-DIFF_BITS-H_FRAC){pax1_r[DIFF_BITS-1]}}, pax1_r,
                    {H_FRAC{1'b0}}}) - bxh1_r;
    numy = $signed({{(NUM_BITS-DIFF_BITS-H_FRAC){pay1_r[DIFF_BITS-1]}}, pay1_r,
                    {H_FRAC{1'b0}}}) - byh1_r;
    // truncate toward zero
    tx = numx[NUM_BITS-1] ? numx + round_adj : numx;
    ty = numy[NUM_BITS-1] ? numy + round_adj : numy;
    px = dx2_r * dx2_r;
    py = dy2_r * dy2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v1_r <= div_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= sq_v;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bxh1_r <= $signed(div_side.bax) * h_s;
      byh1_r <= $signed(div_side.bay) * h_s;
      pax1_r <= div_side.pax;
      pay1_r <= div_side.pay;
      bg1_r  <= div_side.bg;

      dx2_r <= tx[H_FRAC +: DX_BITS];
      dy2_r <= ty[H_FRAC +: DX_BITS];
      bg2_r <= bg1_r;

      sqx3_r <= px[SQ_BITS-2:0];
      sqy3_r <= py[SQ_BITS-2:0];
      bg3_r  <= bg2_r;

      sq4_r <= {1'b0, sqx3_r} + {1'b0, sqy3_r};
      bg4_r <= bg3_r;
    end
  end

  cslpb_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .in_sq     (sq4_r),
    .in_bg     (bg4_r),
    .out_valid (sq_v),
    .out_root  (root_len),
    .out_bg    (sq_bg)
  );

  always_comb begin
    rad128 = ({8'b0, cfg.width} + (WIDTH_BITS+8)'(1)) << 7;
    diff   = rad128 - root_len[WIDTH_BITS+7:0];
    if ({{(ROOT_BITS-WIDTH_BITS-8){1'b0}}, rad128} <= root_len) begin
      t = '0;
    end else if (diff > (WIDTH_BITS+8)'(256)) begin
      t = 9'd256;
    end else begin
      t = diff[8:0];
    end
    t255 = {t, 8'b0} - {8'b0, t};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cov5_r <= t255[15:8];
      bg5_r  <= sq_bg;

      xr6_r  <= mix_pre({1'b0, cfg.color[15:11]}, {1'b0, bg5_r[15:11]}, cov5_r);
      xg6_r  <= mix_pre(cfg.color[10:5], bg5_r[10:5], cov5_r);
      xb6_r  <= mix_pre({1'b0, cfg.color[4:0]}, {1'b0, bg5_r[4:0]}, cov5_r);
      cov6_r <= cov5_r;

      col7_r <= {5'(mix_post(xr6_r)), mix_post(xg6_r), 5'(mix_post(xb6_r))};
      cov7_r <= cov6_r;
    end
  end

  assign oq_push = en && v7_r;
  assign oq_pop  = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_r <= !oq_wr_r;
      end
      if (oq_pop) begin
        oq_rd_r <= !oq_rd_r;
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (oq_pop && !oq_push) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_col_r[oq_wr_r] <= col7_r;
      oq_cov_r[oq_wr_r] <= cov7_r;
    end
  end

  assign out_empty         = (oq_cnt_r == '0);
  assign out_blended_color = oq_col_r[oq_rd_r];
  assign out_coverage      = oq_cov_r[oq_rd_r];
  assign stat.count        = {1'b0, oq_cnt_r};

endmodule

// File: src/capsule_sdf_line_pixel_blend.sv
// Throughput: one pixel per cycle, stalled while the mid queue or the result
// queue is full; the divider (16 stages) and square root (22 stages) are fully
// pipelined, a 4-entry queue sits between front and back.
// Reset (synchronous, active low) empties all queues and pipelines and sets
// line_width to 1 and line_color to 0xFFFF; no clearing pass is needed.
module capsule_sdf_line_pixel_blend (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_push,
  output logic                                    in_full,
  input  logic [cslpb_pkg::PIX_BITS-1:0]          in_pixel_x,
  input  logic [cslpb_pkg::PIX_BITS-1:0]          in_pixel_y,
  input  logic signed [cslpb_pkg::COORD_BITS-1:0] in_start_x,
  input  logic signed [cslpb_pkg::COORD_BITS-1:0] in_start_y,
  input  logic signed [cslpb_pkg::COORD_BITS-1:0] in_end_x,
  input  logic signed [cslpb_pkg::COORD_BITS-1:0] in_end_y,
  input  logic [cslpb_pkg::COLOR_BITS-1:0]        in_background_color,
  output logic                                    out_empty,
  input  logic                                    out_pop,
  output logic [cslpb_pkg::COLOR_BITS-1:0]        out_blended_color,
  output logic [cslpb_pkg::COV_BITS-1:0]          out_coverage,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [cslpb_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [cslpb_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import cslpb_pkg::*;

`include "capsule_sdf_line_pixel_blend_assert.svh"

  logic [WIDTH_BITS-1:0] line_width_r;
  logic [COLOR_BITS-1:0] line_color_r;
  cfg_t                  cfg;

  logic  mq_push, mq_pop, mq_empty, mq_full;
  work_t mq_in, mq_out;
  stat_t mq_stat, bk_stat;

  assign cfg_ready = 1'b1;
  assign cfg.width = line_width_r;
  assign cfg.color = line_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= WIDTH_BITS'(1);
      line_color_r <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LINE_WIDTH: line_width_r <= cfg_data[WIDTH_BITS-1:0];
        REG_LINE_COLOR: line_color_r <= cfg_data[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  cslpb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .pixel_x          (in_pixel_x),
    .pixel_y          (in_pixel_y),
    .start_x          (in_start_x),
    .start_y          (in_start_y),
    .end_x            (in_end_x),
    .end_y            (in_end_y),
    .background_color (in_background_color),
    .q_push           (mq_push),
    .q_data           (mq_in),
    .q_full           (mq_full)
  );

  cslpb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mq_push),
    .push_data (mq_in),
    .pop       (mq_pop),
    .pop_data  (mq_out),
    .empty     (mq_empty),
    .full      (mq_full),
    .stat      (mq_stat)
  );

  cslpb_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (mq_empty),
    .q_pop             (mq_pop),
    .q_data            (mq_out),
    .cfg               (cfg),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_blended_color (out_blended_color),
    .out_coverage      (out_coverage),
    .stat              (bk_stat)
  );

  `CSLPB_NEVER(a_midq_bound, mq_stat.count > CNT_BITS'(MIDQ_DEPTH), "mid queue overflow")
  `CSLPB_NEVER(a_outq_bound, bk_stat.count > CNT_BITS'(2), "result queue overflow")
  `CSLPB_AFTER_RESET(a_rst_idle, out_empty && !in_full, "not idle after reset")

endmodule

// File: dv/capsule_sdf_line_pixel_blend_tb.sv
// Self-checking bench for the capsule line shader: random and directed pixels,
// an internal fixed-point shading predictor, and a scoreboard of expected colors.
// Depends on cslpb_pkg and capsule_sdf_line_pixel_blend.
module capsule_sdf_line_pixel_blend_tb;
  import cslpb_pkg::*;

  typedef struct packed {
    logic [PIX_BITS-1:0]          px;
    logic [PIX_BITS-1:0]          py;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic [COLOR_BITS-1:0]        bg;
  } pixel_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] color;
    logic [COV_BITS-1:0]   cov;
  } shade_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [PIX_BITS-1:0] in_pixel_x = '0;
  logic [PIX_BITS-1:0] in_pixel_y = '0;
  logic signed [COORD_BITS-1:0] in_start_x = '0, in_start_y = '0;
  logic signed [COORD_BITS-1:0] in_end_x = '0, in_end_y = '0;
  logic [COLOR_BITS-1:0] in_background_color = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [COLOR_BITS-1:0] out_blended_color;
  logic [COV_BITS-1:0] out_coverage;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  capsule_sdf_line_pixel_blend dut (.*);

  always #4 clk = ~clk;

  logic [WIDTH_BITS-1:0] cur_width = 8'd1;
  logic [COLOR_BITS-1:0] cur_color = 16'hFFFF;
  pixel_t pending_pixels[$];
  shade_t expected_shades[$];
  int errors = 0;
  bit stim_done = 1'b0;

  function automatic longint root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int unsigned mix_chan(int unsigned fg, int unsigned bgc, int unsigned a);
    int unsigned x;
    x = fg * a + bgc * (255 - a) + 128;
    return (x * 32'h8081) >> 23;
  endfunction

  function automatic shade_t shade_pixel(pixel_t p);
    longint pax, pay, bax, bay, top, len2, h, dx, dy, rdist, t;
    longint unsigned sq;
    int unsigned cov, r, g, b;
    shade_t s;
    pax = longint'(p.px) - longint'(p.ax);
    pay = longint'(p.py) - longint'(p.ay);
    bax = longint'(p.bx) - longint'(p.ax);
    bay = longint'(p.by) - longint'(p.ay);
    top = pax * bax + pay * bay;
    len2 = bax * bax + bay * bay;
    if (len2 == 0 || top >= len2) h = 65536;
    else if (top <= 0) h = 0;
    else h = (top * 65536) / len2;
    dx = (pax * 65536 - bax * h) / 65536;
    dy = (pay * 65536 - bay * h) / 65536;
    sq = dx * dx + dy * dy;
    rdist = root64(sq << 16);
    t = (longint'(cur_width) + 1) * 128 - rdist;
    if (t < 0) t = 0;
    if (t > 256) t = 256;
    cov = int'((t * 255) >> 8);
    r = mix_chan(cur_color[15:11], p.bg[15:11], cov);
    g = mix_chan(cur_color[10:5], p.bg[10:5], cov);
    b = mix_chan(cur_color[4:0], p.bg[4:0], cov);
    s.color = {r[4:0], g[5:0], b[4:0]};
    s.cov = cov[7:0];
    return s;
  endfunction

  // driver
  int push_wait = 0;
  always @(posedge clk) begin
    int gap;
    gap = push_wait;
    if (in_push && !in_full) begin
      expected_shades.push_back(shade_pixel(pixel_t'({in_pixel_x, in_pixel_y, in_start_x,
        in_start_y, in_end_x, in_end_y, in_background_color})));
      void'(pending_pixels.pop_front());
      gap = $urandom_range(0, 14);
    end
    if (in_push && in_full) begin
      // hold the transaction until it is taken
    end else if (gap > 0) begin
      in_push <= 1'b0;
      push_wait <= gap - 1;
    end else if (pending_pixels.size() != 0) begin
      in_push <= 1'b1;
      {in_pixel_x, in_pixel_y, in_start_x, in_start_y, in_end_x, in_end_y,
       in_background_color} <= pending_pixels[0];
    end else begin
      in_push <= 1'b0;
    end
  end

  // monitor
  int pop_wait = 0;
  always @(posedge clk) begin
    int gap;
    gap = pop_wait;
    if (out_pop && !out_empty) begin
      if (expected_shades.size() == 0) begin
        $error("result with nothing expected: blended_color %h", out_blended_color);
        errors++;
      end else begin
        shade_t e;
        e = expected_shades.pop_front();
        if (out_blended_color !== e.color) begin
          $error("blended_color expected %h actual %h", e.color, out_blended_color);
          errors++;
        end
        if (out_coverage !== e.cov) begin
          $error("coverage expected %0d actual %0d", e.cov, out_coverage);
          errors++;
        end
      end
      gap = $urandom_range(0, 14);
    end
    if (gap > 0) begin
      out_pop <= 1'b0;
      pop_wait <= gap - 1;
    end else begin
      out_pop <= 1'b1;
    end
  end

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || in_push || expected_shades.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    wait_drained();
    repeat (60) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_LINE_WIDTH) cur_width = val[7:0];
    else if (idx == REG_LINE_COLOR) cur_color = val;
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    p = pixel_t'({$urandom, $urandom, $urandom});
    // mostly near the segment so coverage varies
    if ($urandom_range(0, 3) != 0) begin
      p.px = PIX_BITS'($urandom_range(0, 300));
      p.py = PIX_BITS'($urandom_range(0, 300));
      p.ax = COORD_BITS'($urandom_range(0, 300) - 20);
      p.ay = COORD_BITS'($urandom_range(0, 300) - 20);
      p.bx = ($urandom_range(0, 7) == 0) ? p.ax :
             COORD_BITS'(p.ax + $urandom_range(0, 80) - 40);
      p.by = COORD_BITS'(p.ay + $urandom_range(0, 80) - 40);
      if ($urandom_range(0, 1)) begin
        p.px = PIX_BITS'(p.ax + $urandom_range(0, 40) - 20);
        p.py = PIX_BITS'(p.ay + $urandom_range(0, 40) - 20);
      end
    end
    return p;
  endfunction

  initial begin
    pixel_t p;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, zero length, pixel on line, beyond both ends
    pending_pixels.push_back('{11'd0, 11'd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 16'h0000});
    pending_pixels.push_back('{11'h7FF, 11'h7FF, -12'sd2048, -12'sd2048, 12'sd2047,
                               12'sd2047, 16'hFFFF});
    pending_pixels.push_back('{11'h7FF, 11'd0, 12'sd2047, -12'sd2048, -12'sd2048,
                               12'sd2047, 16'h1234});
    pending_pixels.push_back('{11'd5, 11'd5, 12'sd0, 12'sd0, 12'sd10, 12'sd10, 16'h0000});
    pending_pixels.push_back('{11'd5, 11'd6, 12'sd0, 12'sd0, 12'sd10, 12'sd10, 16'hF800});
    pending_pixels.push_back('{11'd20, 11'd20, 12'sd0, 12'sd0, 12'sd10, 12'sd10, 16'h07E0});
    pending_pixels.push_back('{11'd0, 11'd0, 12'sd3, 12'sd3, 12'sd10, 12'sd10, 16'h001F});
    pending_pixels.push_back('{11'd7, 11'd7, 12'sd7, 12'sd7, 12'sd7, 12'sd7, 16'hAAAA});
    pending_pixels.push_back('{11'd0, 11'd0, 12'sd2047, 12'sd2047, 12'sd2047, 12'sd2047,
                               16'h5555});
    wait_drained();
    write_reg(REG_LINE_WIDTH, 16'd255);
    write_reg(REG_LINE_COLOR, 16'h0000);
    write_reg(2'd3, 16'hFFFF);
    pending_pixels.push_back('{11'd5, 11'd100, 12'sd0, 12'sd0, 12'sd10, 12'sd10, 16'hFFFF});
    pending_pixels.push_back('{11'd5, 11'd5, 12'sd0, 12'sd0, 12'sd10, 12'sd10, 16'hFFFF});
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_reg(REG_LINE_WIDTH, 16'd0);
        1: write_reg(REG_LINE_COLOR, 16'hFFFF);
        2: write_reg(REG_LINE_WIDTH, 16'hFF07);
        3: write_reg(REG_LINE_COLOR, CFG_DATA_BITS'($urandom));
        4: write_reg(REG_LINE_WIDTH, CFG_DATA_BITS'($urandom_range(0, 40)));
        default: write_reg(REG_LINE_WIDTH, 16'd1);
      endcase
      for (int i = 0; i < 200; i++) pending_pixels.push_back(random_pixel());
    end
    wait_drained();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_shades.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

// File: capsule_sdf_line_pixel_blend.f
+incdir+src
src/cslpb_pkg.sv
src/cslpb_front.sv
src/cslpb_queue.sv
src/cslpb_div.sv
src/cslpb_sqrt.sv
src/cslpb_back.sv
src/capsule_sdf_line_pixel_blend.sv
dv/capsule_sdf_line_pixel_blend_tb.sv
